// ===== sv/pcs_pkg.sv =====
`default_nettype none

package pcs_pkg;

	// field widths of the channels
	localparam int ELEM_W = 16;
	localparam int SIM_W  = 16;
	localparam int IDX_W  = 3;

	// configuration registers
	localparam int VC_REG_W  = 4;
	localparam int DIM_REG_W = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VECTOR_COUNT = 1'b0,
		REG_DIMENSION    = 1'b1
	} pcs_reg_t;

	// reset values of the registers
	localparam int VC_RESET  = 8;
	localparam int DIM_RESET = 256;

	// parameter defaults
	localparam int DEF_MAX_VECTORS = 8;
	localparam int DEF_MAX_DIM     = 256;

	// cosine unit: quotient of dot^2 * 2^32 / (ni*nj) and its square root
	localparam int QUO_W  = 33;
	localparam int RAD_W  = 34;
	localparam int ROOT_W = 17;
	localparam int SREM_W = 19;
	localparam int MAG_W  = 15;
	localparam int MAG_MAX = 32767;

endpackage

`default_nettype wire

// ===== sv/pcs_queue.sv =====
`default_nettype none

module pcs_queue
	import pcs_pkg::*;
#(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic      [DATA_W-1:0] head,
	output logic                   full,
	output logic                   empty
);

	logic [DATA_W-1:0] ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("pair queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pair queue read while empty");

endmodule

`default_nettype wire

// ===== sv/pcs_front.sv =====
`default_nettype none

module pcs_front
	import pcs_pkg::*;
#(
	parameter int MAX_VECTORS = DEF_MAX_VECTORS,
	parameter int MAX_DIM     = DEF_MAX_DIM,
	parameter int ROW_W       = $clog2(MAX_VECTORS),
	parameter int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	parameter int NORM_W      = 31 + $clog2(MAX_DIM),
	parameter int JOB_W       = 2 * ROW_W + 1 + 2 * NORM_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [ELEM_W-1:0]       element,
	input  wire logic                    set_done,
	output logic                         wr_en,
	output logic [ROW_W+DIM_W-1:0]       wr_addr,
	output logic [ELEM_W-1:0]            wr_data,
	output logic [DIM_W-1:0]             dim_m1,
	input  wire logic                    q_full,
	output logic                         q_push,
	output logic [JOB_W-1:0]             q_data
);

	typedef enum logic [2:0] {
		F_LOAD,
		F_DRAIN,
		F_ROW,
		F_PAIR,
		F_WAIT
	} front_state_t;

	function automatic int eff_m1(int raw, int maxv);
		int v;
		v = (raw == 0) ? 1 : ((raw > maxv) ? maxv : raw);
		return v - 1;
	endfunction

	front_state_t       state_q;
	logic [ROW_W-1:0]   vc_m1_q;
	logic [DIM_W-1:0]   dim_m1_q;
	logic [ROW_W-1:0]   row_q;
	logic [DIM_W-1:0]   col_q;
	logic [ROW_W-1:0]   i_q;
	logic [ROW_W-1:0]   j_q;
	logic [NORM_W-1:0]  ni_q;
	logic [NORM_W-1:0]  norms_q [MAX_VECTORS];
	logic [NORM_W-1:0]  nacc_q;

	// squaring pipeline
	logic                     v_s1, v_s2;
	logic signed [ELEM_W-1:0] elem_s1;
	logic [ROW_W-1:0]         row_s1, row_s2;
	logic                     first_s1, first_s2;
	logic                     last_s1, last_s2;
	logic [30:0]              sq_s2;
	logic signed [31:0]       sq_full;
	logic [NORM_W-1:0]        nsum;

	logic               accept;
	logic               last_col;
	logic               last_row;
	logic [ROW_W-1:0]   rd_sel;
	logic [NORM_W-1:0]  rd_norm;
	logic               pair_last;

	assign in_stall = (state_q != F_LOAD);
	assign accept   = in_valid && (state_q == F_LOAD);
	assign last_col = (col_q == dim_m1_q);
	assign last_row = (row_q == vc_m1_q);
	assign dim_m1   = dim_m1_q;

	// element write into the vector store
	assign wr_en   = accept;
	assign wr_addr = {row_q, col_q};
	assign wr_data = element;

	// one norm read port shared by the row and pair steps
	assign rd_sel  = (state_q == F_ROW) ? i_q : j_q;
	assign rd_norm = norms_q[rd_sel];

	// pair request into the queue
	assign pair_last = (i_q == vc_m1_q - ROW_W'(1)) && (j_q == vc_m1_q);
	assign q_push    = (state_q == F_PAIR) && !q_full;
	assign q_data    = {i_q, j_q, pair_last, ni_q, rd_norm};

	assign sq_full = elem_s1 * elem_s1;
	assign nsum    = (first_s2 ? '0 : nacc_q) + NORM_W'(sq_s2);

	// squaring stages
	always_ff @(posedge clk) begin
		elem_s1  <= element;
		row_s1   <= row_q;
		first_s1 <= (col_q == '0);
		last_s1  <= last_col;
		sq_s2    <= sq_full[30:0];
		row_s2   <= row_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
	end

	// norm accumulation, one row at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			nacc_q <= '0;
			for (int r = 0; r < MAX_VECTORS; r++) begin
				norms_q[r] <= '0;
			end
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (v_s2) begin
				nacc_q <= nsum;
				if (last_s2) norms_q[row_s2] <= nsum;
			end
		end
	end

	// load counters and pair sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_LOAD;
			vc_m1_q  <= ROW_W'(eff_m1(VC_RESET, MAX_VECTORS));
			dim_m1_q <= DIM_W'(eff_m1(DIM_RESET, MAX_DIM));
			row_q    <= '0;
			col_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			ni_q     <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (pcs_reg_t'(cfg_index))
					REG_VECTOR_COUNT: vc_m1_q <=
						ROW_W'(eff_m1(int'(cfg_wdata[VC_REG_W-1:0]), MAX_VECTORS));
					REG_DIMENSION: dim_m1_q <=
						DIM_W'(eff_m1(int'(cfg_wdata[DIM_REG_W-1:0]), MAX_DIM));
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end
			unique case (state_q)
				F_LOAD: begin
					if (accept) begin
						if (!last_col) begin
							col_q <= col_q + DIM_W'(1);
						end else begin
							col_q <= '0;
							if (!last_row) begin
								row_q <= row_q + ROW_W'(1);
							end else begin
								row_q   <= '0;
								state_q <= F_DRAIN;
							end
						end
					end
				end
				F_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						i_q     <= '0;
						state_q <= (vc_m1_q == '0) ? F_LOAD : F_ROW;
					end
				end
				F_ROW: begin
					ni_q    <= rd_norm;
					j_q     <= i_q + ROW_W'(1);
					state_q <= F_PAIR;
				end
				F_PAIR: begin
					if (!q_full) begin
						if (j_q == vc_m1_q) begin
							if (i_q + ROW_W'(1) == vc_m1_q) begin
								state_q <= F_WAIT;
							end else begin
								i_q     <= i_q + ROW_W'(1);
								state_q <= F_ROW;
							end
						end else begin
							j_q <= j_q + ROW_W'(1);
						end
					end
				end
				F_WAIT: begin
					if (set_done) state_q <= F_LOAD;
				end
				default: state_q <= F_LOAD;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/pcs_back.sv =====
`default_nettype none

module pcs_back
	import pcs_pkg::*;
#(
	parameter int MAX_VECTORS = DEF_MAX_VECTORS,
	parameter int MAX_DIM     = DEF_MAX_DIM,
	parameter int ROW_W       = $clog2(MAX_VECTORS),
	parameter int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	parameter int NORM_W      = 31 + $clog2(MAX_DIM),
	parameter int JOB_W       = 2 * ROW_W + 1 + 2 * NORM_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [DIM_W-1:0]        dim_m1,
	input  wire logic                    wr_en,
	input  wire logic [ROW_W+DIM_W-1:0]  wr_addr,
	input  wire logic [ELEM_W-1:0]       wr_data,
	input  wire logic                    q_empty,
	input  wire logic [JOB_W-1:0]        q_data,
	output logic                         q_pop,
	input  wire logic                    out_stall,
	output logic                         out_valid,
	output logic [SIM_W-1:0]             similarity,
	output logic [IDX_W-1:0]             first_index,
	output logic [IDX_W-1:0]             second_index,
	output logic                         last_pair
);

	localparam int DOT_W  = NORM_W + 1;
	localparam int SQ_W   = 2 * NORM_W;
	localparam int STEP_N = (NORM_W > QUO_W) ? NORM_W : QUO_W;
	localparam int STEP_W = $clog2(STEP_N + 1);
	localparam int DEPTH  = MAX_VECTORS * (2 ** DIM_W);

	typedef enum logic [2:0] {
		B_IDLE,
		B_MAC,
		B_MACW,
		B_MUL,
		B_DIV,
		B_SQRT,
		B_OUT
	} back_state_t;

	logic [ELEM_W-1:0] mem [DEPTH];

	back_state_t              state_q;
	logic [ROW_W-1:0]         i_q, j_q;
	logic                     last_q;
	logic [NORM_W-1:0]        ni_q, nj_q;
	logic                     zero_q;
	logic [DIM_W-1:0]         k_q;
	logic signed [ELEM_W-1:0] ra_s1, rb_s1;
	logic signed [31:0]       prod_s2;
	logic                     v_s1, v_s2;
	logic signed [DOT_W-1:0]  dot_q;
	logic                     neg_q;
	logic                     phase_q;
	logic [STEP_W-1:0]        step_q;
	logic [SQ_W-1:0]          mc_q;
	logic [NORM_W-1:0]        mp_q;
	logic [SQ_W-1:0]          macc_q;
	logic [SQ_W-1:0]          sq_q;
	logic [SQ_W-1:0]          p_q;
	logic [SQ_W:0]            rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [RAD_W-1:0]         rad_q;
	logic [ROOT_W-1:0]        root_q;
	logic [SREM_W-1:0]        srem_q;
	logic [MAG_W-1:0]         mag_q;

	logic [NORM_W-1:0]  dot_abs;
	logic [SQ_W-1:0]    macc_nx;
	logic [SQ_W:0]      div_t;
	logic               div_ge;
	logic [QUO_W-1:0]   quo_nx;
	logic [SREM_W+1:0]  sq_t;
	logic [SREM_W+1:0]  sq_trial;
	logic               sq_ge;
	logic [ROOT_W-1:0]  root_nx;
	logic [ROOT_W:0]    rnd;
	logic [MAG_W-1:0]   mag_nx;
	logic               out_free;
	logic [MAG_W:0]     mag_ext;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign out_free = !out_valid || !out_stall;

	// magnitude of the finished dot product
	assign dot_abs = dot_q[DOT_W-1] ? NORM_W'(-dot_q) : NORM_W'(dot_q);

	// shift-add multiplier step
	assign macc_nx = macc_q + (mp_q[0] ? mc_q : '0);

	// restoring division step, one quotient bit
	assign div_t  = (step_q == '0) ? rem_q : {rem_q[SQ_W-1:0], 1'b0};
	assign div_ge = (div_t >= {1'b0, p_q});
	assign quo_nx = {quo_q[QUO_W-2:0], div_ge};

	// square root step, one root bit from two radicand bits
	assign sq_t     = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign sq_trial = (SREM_W + 2)'({root_q, 2'b01});
	assign sq_ge    = (sq_t >= sq_trial);
	assign root_nx  = {root_q[ROOT_W-2:0], sq_ge};

	// round to the nearest odd root and saturate
	assign rnd    = (ROOT_W + 1)'(root_nx) + (ROOT_W + 1)'(1);
	assign mag_nx = (rnd[ROOT_W:1] > ROOT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : rnd[MAG_W:1];

	assign mag_ext = {1'b0, mag_q};

	// vector store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		ra_s1   <= mem[{i_q, k_q}];
		rb_s1   <= mem[{j_q, k_q}];
		prod_s2 <= ra_s1 * rb_s1;
	end

	// pair sequencer, multiply-accumulate, cosine unit and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid    <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			last_q       <= 1'b0;
			ni_q         <= '0;
			nj_q         <= '0;
			zero_q       <= 1'b0;
			dot_q        <= '0;
			neg_q        <= 1'b0;
			phase_q      <= 1'b0;
			step_q       <= '0;
			mc_q         <= '0;
			mp_q         <= '0;
			macc_q       <= '0;
			sq_q         <= '0;
			p_q          <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			rad_q        <= '0;
			root_q       <= '0;
			srem_q       <= '0;
			mag_q        <= '0;
			similarity   <= '0;
			first_index  <= '0;
			second_index <= '0;
			last_pair    <= 1'b0;
		end else begin
			v_s1 <= (state_q == B_MAC);
			v_s2 <= v_s1;
			if (v_s2) dot_q <= dot_q + DOT_W'(prod_s2);
			if (out_valid && !out_stall) out_valid <= 1'b0;

			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						{i_q, j_q, last_q, ni_q, nj_q} <= q_data;
						zero_q  <= (q_data[2*NORM_W-1:NORM_W] == '0) ||
						           (q_data[NORM_W-1:0] == '0);
						k_q     <= '0;
						dot_q   <= '0;
						state_q <= B_MAC;
					end
				end
				B_MAC: begin
					if (k_q == dim_m1) begin
						state_q <= B_MACW;
					end else begin
						k_q <= k_q + DIM_W'(1);
					end
				end
				B_MACW: begin
					if (!v_s1 && !v_s2) begin
						neg_q   <= dot_q[DOT_W-1];
						mc_q    <= SQ_W'(dot_abs);
						mp_q    <= dot_abs;
						macc_q  <= '0;
						step_q  <= '0;
						phase_q <= 1'b0;
						mag_q   <= '0;
						state_q <= zero_q ? B_OUT : B_MUL;
					end
				end
				B_MUL: begin
					mc_q   <= {mc_q[SQ_W-2:0], 1'b0};
					mp_q   <= mp_q >> 1;
					macc_q <= macc_nx;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(NORM_W - 1)) begin
						step_q <= '0;
						macc_q <= '0;
						if (!phase_q) begin
							sq_q    <= macc_nx;
							mc_q    <= SQ_W'(ni_q);
							mp_q    <= nj_q;
							phase_q <= 1'b1;
						end else begin
							p_q     <= macc_nx;
							rem_q   <= {1'b0, sq_q};
							quo_q   <= '0;
							state_q <= B_DIV;
						end
					end
				end
				B_DIV: begin
					rem_q  <= div_ge ? (div_t - {1'b0, p_q}) : div_t;
					quo_q  <= quo_nx;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QUO_W - 1)) begin
						step_q  <= '0;
						rad_q   <= {1'b0, quo_nx};
						root_q  <= '0;
						srem_q  <= '0;
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					srem_q <= SREM_W'(sq_ge ? (sq_t - sq_trial) : sq_t);
					root_q <= root_nx;
					rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						step_q  <= '0;
						mag_q   <= mag_nx;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						similarity   <= neg_q ? SIM_W'(-mag_ext) : SIM_W'(mag_ext);
						first_index  <= IDX_W'(i_q);
						second_index <= IDX_W'(j_q);
						last_pair    <= last_q;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	a_mac_drained: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == B_MAC || state_q == B_MACW))
		else $error("product arrived after the dot product was taken");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV && step_q != '0) |-> (rem_q < {1'b0, p_q}))
		else $error("division remainder not below divisor");

endmodule

`default_nettype wire

// ===== sv/pairwise_cosine_similarity_core.sv =====
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------------------
// input     | in_valid  | in_stall  | element
// output    | out_valid | out_stall | similarity, first_index, second_index, last_pair
// config    | cfg_wen   | -         | cfg_index, cfg_wdata
//
// loading takes one element per cycle, vector_count * dimension elements per set
// each pair passes through the shared multiply-accumulate, shift-add
// multiplier, divider and square root unit; a pair with a zero norm
// skips the multiplier, divider and square root after the dot product
// input stalls from the last element of a set until the cycle after the last
// pair result is taken; with one vector, only until the squaring pipeline drains
// no clearing pass after reset; the output register lets the next pair start
// while a result waits under out_stall
`default_nettype none

module pairwise_cosine_similarity_core
	import pcs_pkg::*;
#(
	parameter int MAX_VECTORS = DEF_MAX_VECTORS,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ELEM_W-1:0]    element,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [SIM_W-1:0]          similarity,
	output logic [IDX_W-1:0]          first_index,
	output logic [IDX_W-1:0]          second_index,
	output logic                      last_pair
);

	localparam int ROW_W  = $clog2(MAX_VECTORS);
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int NORM_W = 31 + $clog2(MAX_DIM);
	localparam int JOB_W  = 2 * ROW_W + 1 + 2 * NORM_W;

	logic                   wr_en;
	logic [ROW_W+DIM_W-1:0] wr_addr;
	logic [ELEM_W-1:0]      wr_data;
	logic [DIM_W-1:0]       dim_m1;
	logic                   q_push, q_pop, q_full, q_empty;
	logic [JOB_W-1:0]       q_in, q_head;
	logic                   set_done;

	// the set is finished when its final pair result is taken at the output
	assign set_done = out_valid && !out_stall && last_pair;

	pcs_front #(
		.MAX_VECTORS (MAX_VECTORS),
		.MAX_DIM     (MAX_DIM),
		.ROW_W       (ROW_W),
		.DIM_W       (DIM_W),
		.NORM_W      (NORM_W),
		.JOB_W       (JOB_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.element   (element),
		.set_done  (set_done),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.dim_m1    (dim_m1),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	pcs_queue #(
		.DATA_W (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	pcs_back #(
		.MAX_VECTORS (MAX_VECTORS),
		.MAX_DIM     (MAX_DIM),
		.ROW_W       (ROW_W),
		.DIM_W       (DIM_W),
		.NORM_W      (NORM_W),
		.JOB_W       (JOB_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.dim_m1       (dim_m1),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.q_empty      (q_empty),
		.q_data       (q_head),
		.q_pop        (q_pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.similarity   (similarity),
		.first_index  (first_index),
		.second_index (second_index),
		.last_pair    (last_pair)
	);

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top
	import pcs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NVEC = DEF_MAX_VECTORS;
	localparam int NDIM = DEF_MAX_DIM;
	localparam int SETTLE = 900;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [SIM_W-1:0] sim;
		logic [IDX_W-1:0]        lo_idx;
		logic [IDX_W-1:0]        hi_idx;
		logic                    last;
	} pair_result_t;

	// tracks loaded vectors and the pair similarities they should produce
	class cosine_scoreboard;
		logic signed [ELEM_W-1:0] vecs [NVEC][NDIM];
		logic [39:0]              norms [NVEC];
		int unsigned              row, col;
		logic [VC_REG_W-1:0]      count_reg;
		logic [DIM_REG_W-1:0]     dim_reg;
		pair_result_t             pending_pairs [$];
		int                       mismatches;
		int                       checked;

		function new();
			foreach (norms[i]) norms[i] = '0;
			row = 0;
			col = 0;
			count_reg = VC_RESET;
			dim_reg = DIM_RESET;
			mismatches = 0;
			checked = 0;
		endfunction

		function int unsigned eff_count();
			if (count_reg == 0) return 1;
			if (count_reg > NVEC) return NVEC;
			return count_reg;
		endfunction

		function int unsigned eff_dim();
			if (dim_reg == 0) return 1;
			if (dim_reg > NDIM) return NDIM;
			return dim_reg;
		endfunction

		function void write_reg(pcs_reg_t idx, logic [CFG_W-1:0] val);
			if (idx == REG_VECTOR_COUNT) count_reg = val[VC_REG_W-1:0];
			else dim_reg = val[DIM_REG_W-1:0];
			row = 0;
			col = 0;
		endfunction

		// exact rounded q1.15 of dot / sqrt(ni*nj)
		function logic signed [SIM_W-1:0] cosine(longint dot, logic [39:0] ni, logic [39:0] nj);
			logic [127:0] lhs, prodv, rhs, mag, oddw;
			int unsigned lo, hi, mid;
			if (ni == 0 || nj == 0) return '0;
			mag = (dot < 0) ? 128'(-dot) : 128'(dot);
			prodv = 128'(ni) * 128'(nj);
			lhs = (mag * mag) << 32;
			lo = 0;
			hi = 32768;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				oddw = 128'(2 * mid - 1);
				rhs = prodv * oddw * oddw;
				if (lhs >= rhs) lo = mid;
				else hi = mid - 1;
			end
			if (lo > MAG_MAX) lo = MAG_MAX;
			return (dot < 0) ? -SIM_W'(lo) : SIM_W'(lo);
		endfunction

		function void note_element(logic signed [ELEM_W-1:0] v);
			int unsigned vc, dm;
			longint dot;
			pair_result_t exp_pair;
			vc = eff_count();
			dm = eff_dim();
			vecs[row][col] = v;
			norms[row] = ((col == 0) ? 40'd0 : norms[row]) + 40'(longint'(v) * longint'(v));
			if (col + 1 < dm) begin
				col++;
				return;
			end
			col = 0;
			if (row + 1 < vc) begin
				row++;
				return;
			end
			row = 0;
			for (int i = 0; i < vc; i++) begin
				for (int j = i + 1; j < vc; j++) begin
					dot = 0;
					for (int k = 0; k < dm; k++)
						dot += longint'(vecs[i][k]) * longint'(vecs[j][k]);
					exp_pair.sim = cosine(dot, norms[i], norms[j]);
					exp_pair.lo_idx = i[IDX_W-1:0];
					exp_pair.hi_idx = j[IDX_W-1:0];
					exp_pair.last = (i + 2 == vc) && (j + 1 == vc);
					pending_pairs = {pending_pairs, exp_pair};
				end
			end
		endfunction

		function void check_pair(pair_result_t got);
			pair_result_t want;
			checked++;
			if (pending_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pair result: sim=%0d (%0d,%0d) last=%0d",
						got.sim, got.lo_idx, got.hi_idx, got.last);
				return;
			end
			want = pending_pairs.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pair mismatch: expected sim=%0d (%0d,%0d) last=%0d,",
						want.sim, want.lo_idx, want.hi_idx, want.last,
						" got sim=%0d (%0d,%0d) last=%0d",
						got.sim, got.lo_idx, got.hi_idx, got.last);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_VECTOR_COUNT;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ELEM_W-1:0]    element = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SIM_W-1:0]     similarity;
	logic [IDX_W-1:0]     first_index;
	logic [IDX_W-1:0]     second_index;
	logic                 last_pair;

	cosine_scoreboard sb = new();
	bit               calm = 1'b0;
	longint           cycles = 0;
	int               sets_sent = 0;
	logic signed [ELEM_W-1:0] set_buf [NVEC][NDIM];

	pairwise_cosine_similarity_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.element      (element),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.similarity   (similarity),
		.first_index  (first_index),
		.second_index (second_index),
		.last_pair    (last_pair)
	);

	always #1 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// result side: check accepted pairs, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pair('{similarity, first_index, second_index, last_pair});
		out_stall <= !calm && ($urandom_range(99) < 33);
	end

	// register write, with cfg_wen dropped again before the task returns
	task automatic write_reg(pcs_reg_t idx, int unsigned val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.write_reg(idx, CFG_W'(val));
		@(posedge clk);
	endtask

	// one element request, with an optional idle gap first
	task automatic send_element(logic [ELEM_W-1:0] v);
		int gap;
		gap = (!calm && $urandom_range(99) < 33) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_element(v);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return '0;
			3: return ELEM_W'($urandom_range(0, 64) - 32);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// random set: rows are random, zero, copies, negations or halves of row 0
	task automatic send_random_set();
		int unsigned vc, dm, mode;
		vc = sb.eff_count();
		dm = sb.eff_dim();
		for (int r = 0; r < vc; r++) begin
			mode = (r == 0) ? 0 : $urandom_range(9);
			if ($urandom_range(9) == 0) mode = 9;
			for (int c = 0; c < dm; c++) begin
				case (mode)
					6: set_buf[r][c] = set_buf[0][c];
					7: set_buf[r][c] = -set_buf[0][c];
					8: set_buf[r][c] = set_buf[0][c] >>> 1;
					9: set_buf[r][c] = '0;
					default: set_buf[r][c] = rand_elem();
				endcase
			end
		end
		for (int r = 0; r < vc; r++)
			for (int c = 0; c < dm; c++)
				send_element(set_buf[r][c]);
		sets_sent++;
	endtask

	initial begin
		int unsigned vcv, dmv;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identical extremes saturate, opposite vectors, zero norm
		write_reg(REG_VECTOR_COUNT, 2);
		write_reg(REG_DIMENSION, 2);
		send_element(16'h7fff); send_element(16'h8000);
		send_element(16'h7fff); send_element(16'h8000);
		send_element(16'd1); send_element(16'd2);
		send_element(-16'sd1); send_element(-16'sd2);
		send_element(16'd0); send_element(16'd0);
		send_element(16'd5); send_element(16'd5);
		settle();
		// single vector gives no pairs; zero count acts as one
		write_reg(REG_VECTOR_COUNT, 0);
		write_reg(REG_DIMENSION, 3);
		send_element(16'h8000); send_element(16'h7fff); send_element(16'h0001);
		settle();
		// oversized count clamps to eight vectors
		write_reg(REG_VECTOR_COUNT, 15);
		write_reg(REG_DIMENSION, 0);
		send_random_set();
		settle();

		// random phases, mostly small sets
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph >= 4 && ph <= 6);
			if ($urandom_range(4) == 0) begin
				vcv = $urandom_range(0, 15);
				dmv = $urandom_range(0, 3);
			end else begin
				vcv = $urandom_range(2, 3);
				dmv = $urandom_range(1, 4);
			end
			write_reg(REG_VECTOR_COUNT, vcv);
			write_reg(REG_DIMENSION, dmv);
			send_random_set();
			send_random_set();
			settle();
		end
		calm = 1'b0;

		if (sb.pending_pairs.size() != 0) begin
			sb.mismatches++;
			$display("%0d expected pair results never arrived", sb.pending_pairs.size());
		end
		$display("covered %0d vector sets, %0d pair results checked, %0d mismatches",
			sets_sent + 4, sb.checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/pcs_pkg.sv
sv/pcs_queue.sv
sv/pcs_front.sv
sv/pcs_back.sv
sv/pairwise_cosine_similarity_core.sv
bench/tb_top.sv
